FILE: rtl/ogru_pkg.sv
// Package for the occupancy grid ray update block.
// Holds default sizes, register indexes, reset values, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package ogru_pkg;

  localparam int DEF_MAX_COLS  = 512;
  localparam int DEF_MAX_ROWS  = 512;
  localparam int DEF_ODDS_BITS = 16;

  // width of map dimensions and coordinate compares (grid sizes up to 4096)
  localparam int DIM_W = 13;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_DELTA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_DELTA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ODDS_LIMIT = 3'd4;

  localparam logic [9:0]         RST_MAP_WIDTH  = 10'd512;
  localparam logic [9:0]         RST_MAP_HEIGHT = 10'd512;
  localparam logic signed [15:0] RST_FREE_DELTA = -16'sd217;
  localparam logic [14:0]        RST_OCC_DELTA  = 15'd217;
  localparam logic [14:0]        RST_ODDS_LIMIT = 15'd32767;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_START_OFF = 2'd1;
  localparam logic [1:0] STAT_END_OFF   = 2'd2;
  localparam logic [1:0] STAT_READ_OFF  = 2'd3;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_PREP   = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_FINISH = 7'b0100000,
    ST_RDWAIT = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/ogru_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ogru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/occupancy_grid_ray_update_top.sv
// Ray update: SETUP, PREP, WALK along the ray, then FINISH, which raises the
// registered result strobe; an off-map ray gets its result from SETUP, a cell read
// from SETUP and RDWAIT. One cell read-modify-write per cycle on the grid RAM; the
// next start goes in as the result is shown. After reset the grid RAM is zeroed, one
// cell a cycle, keeping busy high until all are cleared. The receiver cannot stall.
// Depends on ogru_pkg and ogru_ram.
`default_nettype none

module occupancy_grid_ray_update_top #(
  parameter int MAX_COLS  = ogru_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS  = ogru_pkg::DEF_MAX_ROWS,
  parameter int ODDS_BITS = ogru_pkg::DEF_ODDS_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_mode,
  input  wire logic [11:0]                     in_start_x,
  input  wire logic [11:0]                     in_start_y,
  input  wire logic [11:0]                     in_end_x,
  input  wire logic [11:0]                     in_end_y,
  input  wire logic [8:0]                      in_read_col,
  input  wire logic [8:0]                      in_read_row,
  // result
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [9:0]                           out_cells_updated,
  output logic signed [15:0]                   out_cell_value,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ogru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ogru_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ogru_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]       LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]       COL_STEP  = AW'(MAX_COLS);
  localparam logic [AW-1:0]       ONE_STEP  = AW'(1);
  localparam logic [DIM_W-1:0]    MAXC      = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0]    MAXR      = DIM_W'(MAX_ROWS);
  localparam logic signed [32:0]  CAP       = (33'sd1 <<< (ODDS_BITS - 1)) - 33'sd1;

  // configuration registers
  logic [9:0]         map_width_r;
  logic [9:0]         map_height_r;
  logic signed [15:0] free_delta_r;
  logic [14:0]        occ_delta_r;
  logic [14:0]        odds_limit_r;

  // sequencer
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  // latched command word
  logic              mode_r;
  logic [11:0]       sx_r, sy_r, ex_r, ey_r;
  logic [8:0]        col_r, row_r;

  // walk setup and walk state
  logic [11:0]       adx_r, adx_nxt, ady_r, ady_nxt;
  logic              xpos_r, xpos_nxt, ypos_r, ypos_nxt;
  logic [11:0]       mlen_r, mlen_nxt, mn_r, mn_nxt;
  logic [11:0]       idx_r, idx_nxt;
  logic signed [13:0] d_r, d_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     maj_step_r, maj_step_nxt, min_step_r, min_step_nxt;

  // pending write-back of the cell read last cycle
  logic              pend_valid_r, pend_valid_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;

  // result
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [9:0]        out_cnt_r, out_cnt_nxt;
  logic signed [15:0] out_val_r, out_val_nxt;

  // grid RAM ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [ODDS_BITS-1:0] wr_data, rd_data;

  logic [DIM_W-1:0]  eff_w, eff_h;
  logic              start_on, end_on, read_on;
  logic signed [12:0] dx_s, dy_s;
  logic [AW-1:0]     start_addr, read_addr;
  logic signed [32:0] lim, cur_ext, delta_ext, sum, sat;
  logic signed [31:0] rd_ext;
  logic              accept;

  function automatic logic coord_on(input logic [11:0] c, input logic [DIM_W-1:0] lim_c);
    return !c[11] && (DIM_W'(c[10:0]) < lim_c);
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_cells_updated = out_cnt_r;
  assign out_cell_value    = out_val_r;

  assign eff_w = (DIM_W'(map_width_r) > MAXC) ? MAXC : DIM_W'(map_width_r);
  assign eff_h = (DIM_W'(map_height_r) > MAXR) ? MAXR : DIM_W'(map_height_r);

  assign start_on = coord_on(sx_r, eff_w) && coord_on(sy_r, eff_h);
  assign end_on   = coord_on(ex_r, eff_w) && coord_on(ey_r, eff_h);
  assign read_on  = (DIM_W'(col_r) < eff_w) && (DIM_W'(row_r) < eff_h);

  assign dx_s = signed'(13'({1'b0, ex_r[10:0]})) - signed'(13'({1'b0, sx_r[10:0]}));
  assign dy_s = signed'(13'({1'b0, ey_r[10:0]})) - signed'(13'({1'b0, sy_r[10:0]}));

  assign start_addr = AW'(sy_r[10:0]) * COL_STEP + AW'(sx_r[10:0]);
  assign read_addr  = AW'(row_r) * COL_STEP + AW'(col_r);

  // saturating add on the word read last cycle
  assign lim       = (33'(odds_limit_r) < CAP) ? 33'(odds_limit_r) : CAP;
  assign cur_ext   = 33'(signed'(rd_data));
  assign delta_ext = pend_last_r ? signed'(33'(occ_delta_r)) : 33'(free_delta_r);
  assign sum       = cur_ext + delta_ext;
  always_comb begin
    sat = sum;
    if (sum > lim) begin
      sat = lim;
    end else if (sum < -lim) begin
      sat = -lim;
    end
  end
  assign rd_ext = 32'(signed'(rd_data));

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = pend_valid_r;
      wr_addr = pend_addr_r;
      wr_data = sat[ODDS_BITS-1:0];
    end
  end

  assign rd_addr = (state_r == ST_SETUP) ? read_addr : addr_r;

  ogru_ram #(
    .WIDTH (ODDS_BITS),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    adx_nxt        = adx_r;
    ady_nxt        = ady_r;
    xpos_nxt       = xpos_r;
    ypos_nxt       = ypos_r;
    mlen_nxt       = mlen_r;
    mn_nxt         = mn_r;
    idx_nxt        = idx_r;
    d_nxt          = d_r;
    addr_nxt       = addr_r;
    maj_step_nxt   = maj_step_r;
    min_step_nxt   = min_step_r;
    pend_valid_nxt = 1'b0;
    pend_last_nxt  = pend_last_r;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_val_nxt    = out_val_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ONE_STEP;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        out_cnt_nxt = '0;
        out_val_nxt = '0;
        if (mode_r) begin
          if (read_on) begin
            state_nxt = ST_RDWAIT;
          end else begin
            out_status_nxt = STAT_READ_OFF;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (!start_on) begin
          out_status_nxt = STAT_START_OFF;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (!end_on) begin
          out_status_nxt = STAT_END_OFF;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          adx_nxt   = dx_s[12] ? 12'(-dx_s) : 12'(dx_s);
          ady_nxt   = dy_s[12] ? 12'(-dy_s) : 12'(dy_s);
          xpos_nxt  = !dx_s[12] && (dx_s != '0);
          ypos_nxt  = !dy_s[12] && (dy_s != '0);
          addr_nxt  = start_addr;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (adx_r > ady_r) begin
          mlen_nxt     = adx_r;
          mn_nxt       = ady_r;
          maj_step_nxt = xpos_r ? ONE_STEP : -ONE_STEP;
          min_step_nxt = ypos_r ? COL_STEP : -COL_STEP;
          d_nxt        = signed'(14'({ady_r, 1'b0})) - signed'(14'(adx_r));
        end else begin
          mlen_nxt     = ady_r;
          mn_nxt       = adx_r;
          maj_step_nxt = ypos_r ? COL_STEP : -COL_STEP;
          min_step_nxt = xpos_r ? ONE_STEP : -ONE_STEP;
          d_nxt        = signed'(14'({adx_r, 1'b0})) - signed'(14'(ady_r));
        end
        idx_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // read this cell now, write it back next cycle
        pend_valid_nxt = 1'b1;
        pend_addr_nxt  = addr_r;
        pend_last_nxt  = (idx_r == mlen_r);
        idx_nxt        = idx_r + 12'd1;
        if (d_r >= 0) begin
          addr_nxt = addr_r + maj_step_r + min_step_r;
          d_nxt    = d_r + signed'(14'({mn_r, 1'b0})) - signed'(14'({mlen_r, 1'b0}));
        end else begin
          addr_nxt = addr_r + maj_step_r;
          d_nxt    = d_r + signed'(14'({mn_r, 1'b0}));
        end
        if (idx_r == mlen_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_status_nxt = STAT_OK;
        out_cnt_nxt    = 10'(mlen_r + 12'd1);
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_RDWAIT: begin
        out_status_nxt = STAT_OK;
        out_val_nxt    = rd_ext[15:0];
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      map_width_r  <= RST_MAP_WIDTH;
      map_height_r <= RST_MAP_HEIGHT;
      free_delta_r <= RST_FREE_DELTA;
      occ_delta_r  <= RST_OCC_DELTA;
      odds_limit_r <= RST_ODDS_LIMIT;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAP_WIDTH:  map_width_r  <= cfg_data[9:0];
          CFG_MAP_HEIGHT: map_height_r <= cfg_data[9:0];
          CFG_FREE_DELTA: free_delta_r <= signed'(cfg_data[15:0]);
          CFG_OCC_DELTA:  occ_delta_r  <= cfg_data[14:0];
          CFG_ODDS_LIMIT: odds_limit_r <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      sx_r   <= in_start_x;
      sy_r   <= in_start_y;
      ex_r   <= in_end_x;
      ey_r   <= in_end_y;
      col_r  <= in_read_col;
      row_r  <= in_read_row;
    end
    adx_r         <= adx_nxt;
    ady_r         <= ady_nxt;
    xpos_r        <= xpos_nxt;
    ypos_r        <= ypos_nxt;
    mlen_r        <= mlen_nxt;
    mn_r          <= mn_nxt;
    idx_r         <= idx_nxt;
    d_r           <= d_nxt;
    addr_r        <= addr_nxt;
    maj_step_r    <= maj_step_nxt;
    min_step_r    <= min_step_nxt;
    pend_last_r   <= pend_last_nxt;
    pend_addr_r   <= pend_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_val_r     <= out_val_nxt;
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for occupancy_grid_ray_update_top: ray updates, cell reads,
// register writes. Keeps its own copy of the log-odds grid and registers and checks
// every result word in order. Depends on ogru_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import ogru_pkg::*;

  localparam int GRID_COLS = DEF_MAX_COLS;
  localparam int GRID_ROWS = DEF_MAX_ROWS;
  localparam int CAP_ODDS  = (1 << (DEF_ODDS_BITS - 1)) - 1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam logic MODE_RAY  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct {
    logic              mode;
    logic signed [11:0] sx, sy, ex, ey;
    logic [8:0]        col, row;
  } grid_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic [9:0]         cells;
    logic signed [15:0] value;
  } grid_reply_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_wr_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [11:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [8:0] in_read_col = '0, in_read_row = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [9:0] out_cells_updated;
  logic signed [15:0] out_cell_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  occupancy_grid_ray_update_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_read_col(in_read_col), .in_read_row(in_read_row),
    .out_valid(out_valid), .out_status(out_status),
    .out_cells_updated(out_cells_updated), .out_cell_value(out_cell_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // grid copy and register copy
  shortint odds_grid [GRID_COLS * GRID_ROWS];
  logic [9:0]         map_cols  = RST_MAP_WIDTH;
  logic [9:0]         map_rows  = RST_MAP_HEIGHT;
  logic signed [15:0] free_step = RST_FREE_DELTA;
  logic [14:0]        occ_step  = RST_OCC_DELTA;
  logic [14:0]        odds_cap  = RST_ODDS_LIMIT;

  grid_cmd_t   cmd_backlog [$];
  grid_reply_t results_due [$];
  reg_wr_t     reg_writes [$];
  grid_cmd_t   cmd_on_port;
  int          gap_left = 0;
  int          gap_pct = 0;
  int          hot_x = 0, hot_y = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int eff_cols();
    return (map_cols > GRID_COLS) ? GRID_COLS : int'(map_cols);
  endfunction

  function automatic int eff_rows();
    return (map_rows > GRID_ROWS) ? GRID_ROWS : int'(map_rows);
  endfunction

  function automatic bit cell_on_map(input int x, input int y);
    return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
  endfunction

  function automatic void add_odds(input int x, input int y, input int delta);
    int lim, v;
    lim = (int'(odds_cap) < CAP_ODDS) ? int'(odds_cap) : CAP_ODDS;
    v = int'(odds_grid[y * GRID_COLS + x]) + delta;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    odds_grid[y * GRID_COLS + x] = shortint'(v);
  endfunction

  // Applies one command to the grid copy and returns the word it should produce.
  function automatic grid_reply_t ray_or_read(input grid_cmd_t c);
    grid_reply_t r;
    int sx, sy, ex, ey, dx, dy, xs, ys, mjx, mjy, mnx, mny, len, err, minor, cx, cy, t;
    int occ_i, free_i;
    r.status = STAT_OK;
    r.cells = '0;
    r.value = '0;
    occ_i = occ_step;
    free_i = free_step;
    if (c.mode == MODE_RAY) begin
      sx = c.sx; sy = c.sy; ex = c.ex; ey = c.ey;
      if (!cell_on_map(sx, sy)) begin
        r.status = STAT_START_OFF;
      end else if (!cell_on_map(ex, ey)) begin
        r.status = STAT_END_OFF;
      end else begin
        dx = ex - sx; dy = ey - sy;
        xs = (dx > 0) ? 1 : -1;
        ys = (dy > 0) ? 1 : -1;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > dy) begin
          mjx = xs; mjy = 0; mnx = 0; mny = ys;
        end else begin
          t = dx; dx = dy; dy = t;
          mjx = 0; mjy = ys; mnx = xs; mny = 0;
        end
        len = dx + 1;
        err = 2 * dy - dx;
        minor = 0;
        for (int i = 0; i < len; i++) begin
          cx = sx + i * mjx + minor * mnx;
          cy = sy + i * mjy + minor * mny;
          if (cell_on_map(cx, cy)) begin
            add_odds(cx, cy, (i == len - 1) ? occ_i : free_i);
            r.cells = r.cells + 10'd1;
          end
          // ties step the minor axis
          if (err >= 0) begin
            minor++;
            err -= 2 * dx;
          end
          err += 2 * dy;
        end
      end
    end else begin
      cx = c.col; cy = c.row;
      if (cell_on_map(cx, cy)) r.value = odds_grid[cy * GRID_COLS + cx];
      else r.status = STAT_READ_OFF;
    end
    return r;
  endfunction

  function automatic void commit_reg(input reg_wr_t w);
    case (w.idx)
      CFG_MAP_WIDTH:  map_cols  = w.data[9:0];
      CFG_MAP_HEIGHT: map_rows  = w.data[9:0];
      CFG_FREE_DELTA: free_step = w.data;
      CFG_OCC_DELTA:  occ_step  = w.data[14:0];
      CFG_ODDS_LIMIT: odds_cap  = w.data[14:0];
      default: ;
    endcase
  endfunction

  // Driver: one command word per start/busy handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) results_due.push_back(ray_or_read(cmd_on_port));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cmd_on_port = cmd_backlog.pop_front();
          in_mode     <= cmd_on_port.mode;
          in_start_x  <= cmd_on_port.sx;
          in_start_y  <= cmd_on_port.sy;
          in_end_x    <= cmd_on_port.ex;
          in_end_y    <= cmd_on_port.ey;
          in_read_col <= cmd_on_port.col;
          in_read_row <= cmd_on_port.row;
          start <= 1'b1;
          if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            gap_left <= $urandom_range(1, 18);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string what);
    if (mismatches < 40) $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Monitor: result words cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    grid_reply_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        note_mismatch("result word with nothing outstanding");
      end else begin
        want = results_due.pop_front();
        if (out_status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_cells_updated !== want.cells)
          note_mismatch($sformatf("cells_updated %0d, want %0d",
                                  out_cells_updated, want.cells));
        if (out_cell_value !== want.value)
          note_mismatch($sformatf("cell_value %0d, want %0d", out_cell_value, want.value));
      end
    end
  end

  // Sampled on the falling edge, clear of the rising-edge updates.
  task automatic wait_idle();
    do @(negedge clk);
    while (!(cmd_backlog.size() == 0 && !start && results_due.size() == 0 && !busy));
  endtask

  function automatic void stage_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    reg_wr_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.push_back(w);
  endfunction

  task automatic apply_regs();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_writes[0].idx;
    cfg_data  <= reg_writes[0].data;
    while (reg_writes.size() > 0) begin
      @(posedge clk);
      if (cfg_ready) begin
        commit_reg(reg_writes.pop_front());
        if (reg_writes.size() > 0) begin
          cfg_index <= reg_writes[0].idx;
          cfg_data  <= reg_writes[0].data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  endtask

  function automatic grid_cmd_t mk_ray(input int sx, input int sy, input int ex, input int ey);
    grid_cmd_t c;
    c.mode = MODE_RAY;
    c.sx = 12'(sx); c.sy = 12'(sy); c.ex = 12'(ex); c.ey = 12'(ey);
    c.col = 9'($urandom); c.row = 9'($urandom);
    return c;
  endfunction

  function automatic grid_cmd_t mk_read(input int col, input int row);
    grid_cmd_t c;
    c = mk_ray($urandom, $urandom, $urandom, $urandom);
    c.mode = MODE_READ;
    c.col = 9'(col); c.row = 9'(row);
    return c;
  endfunction

  function automatic int pick_near(input int base, input int span, input int lim);
    int r, v;
    r = $urandom_range(0, 2 * span);
    v = base + r - span;
    if (v > lim - 1) v = lim - 1;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic int off_coord(input int lim);
    int r;
    r = $urandom_range(0, 3);
    case ($urandom_range(0, 2))
      0: return -1 - r;
      1: return lim + r;
      default: return $urandom_range(0, 1) ? -2048 : 2047;
    endcase
  endfunction

  // Mostly on-map rays and reads around a hot spot; some off-map rays and pure noise.
  function automatic grid_cmd_t gen_cmd();
    grid_cmd_t c;
    int w, h, roll, sx, sy, ex, ey;
    w = eff_cols();
    h = eff_rows();
    roll = $urandom_range(0, 99);
    c = mk_ray($urandom, $urandom, $urandom, $urandom);
    if (w == 0 || h == 0 || roll >= 90) begin
      c.mode = 1'($urandom);
    end else if (roll < 65) begin
      if ($urandom_range(0, 39) == 0) begin
        // crosses the whole map
        if ($urandom_range(0, 1)) begin
          sx = 0; ex = w - 1;
          sy = $urandom_range(0, h - 1); ey = $urandom_range(0, h - 1);
        end else begin
          sy = 0; ey = h - 1;
          sx = $urandom_range(0, w - 1); ex = $urandom_range(0, w - 1);
        end
        if ($urandom_range(0, 1)) c = mk_ray(ex, ey, sx, sy);
        else c = mk_ray(sx, sy, ex, ey);
      end else begin
        sx = pick_near(hot_x, 10, w); sy = pick_near(hot_y, 10, h);
        ex = pick_near(sx, 10, w);    ey = pick_near(sy, 10, h);
        if (roll >= 55) begin
          case ($urandom_range(0, 3))
            0: sx = off_coord(w);
            1: sy = off_coord(h);
            2: ex = off_coord(w);
            default: ey = off_coord(h);
          endcase
        end
        c = mk_ray(sx, sy, ex, ey);
      end
    end else begin
      c.mode = MODE_READ;
      if ($urandom_range(0, 4) != 0) begin
        c.col = 9'(pick_near(hot_x, 12, w));
        c.row = 9'(pick_near(hot_y, 12, h));
      end
    end
    return c;
  endfunction

  task automatic run_batch(input int n_items, input int idle_pct);
    gap_pct = idle_pct;
    hot_x = (eff_cols() > 0) ? $urandom_range(0, eff_cols() - 1) : 0;
    hot_y = (eff_rows() > 0) ? $urandom_range(0, eff_rows() - 1) : 0;
    @(negedge clk);
    repeat (n_items) cmd_backlog.push_back(gen_cmd());
    wait_idle();
  endtask

  initial begin : stimulus
    @(negedge clk);
    gap_pct = 15;
    // reset settings: 512 x 512 map
    cmd_backlog.push_back(mk_read(0, 0));
    cmd_backlog.push_back(mk_ray(0, 0, 0, 0));
    cmd_backlog.push_back(mk_read(0, 0));
    cmd_backlog.push_back(mk_ray(0, 0, 511, 0));
    cmd_backlog.push_back(mk_ray(511, 511, 0, 0));
    cmd_backlog.push_back(mk_ray(0, 0, 4, 2));
    cmd_backlog.push_back(mk_ray(3, 1, 0, 9));
    cmd_backlog.push_back(mk_ray(10, 10, 10, 300));
    cmd_backlog.push_back(mk_ray(-1, 0, 5, 5));
    cmd_backlog.push_back(mk_ray(2047, -2048, -2048, 2047));
    cmd_backlog.push_back(mk_ray(5, 5, 512, 5));
    cmd_backlog.push_back(mk_ray(5, 5, 5, -2048));
    cmd_backlog.push_back(mk_ray(0, 512, 3, 3));
    cmd_backlog.push_back(mk_read(511, 511));
    cmd_backlog.push_back(mk_read(4, 2));
    cmd_backlog.push_back(mk_read(2, 1));
    cmd_backlog.push_back(mk_read(511, 0));
    cmd_backlog.push_back(mk_read(10, 300));
    cmd_backlog.push_back(mk_read(0, 9));
    wait_idle();

    // width/height above the grid are capped; extreme deltas saturate quickly
    stage_reg(CFG_MAP_WIDTH,  {6'($urandom), 10'd1023});
    stage_reg(CFG_MAP_HEIGHT, {6'($urandom), 10'd1023});
    stage_reg(CFG_FREE_DELTA, 16'h8000);
    stage_reg(CFG_OCC_DELTA,  {1'($urandom), 15'h7FFF});
    stage_reg(CFG_ODDS_LIMIT, {1'($urandom), 15'h7FFF});
    apply_regs();
    @(negedge clk);
    cmd_backlog.push_back(mk_ray(600, 3, 3, 3));
    cmd_backlog.push_back(mk_ray(7, 7, 7, 7));
    cmd_backlog.push_back(mk_ray(7, 7, 7, 7));
    cmd_backlog.push_back(mk_read(7, 7));
    run_batch(90, 20);

    // zero width: everything is off the map
    stage_reg(CFG_MAP_WIDTH,  16'd0);
    stage_reg(CFG_MAP_HEIGHT, 16'd300);
    apply_regs();
    @(negedge clk);
    cmd_backlog.push_back(mk_read(0, 0));
    run_batch(40, 25);

    stage_reg(CFG_MAP_WIDTH,  16'd37);
    stage_reg(CFG_MAP_HEIGHT, 16'd20);
    stage_reg(CFG_FREE_DELTA, RST_FREE_DELTA);
    stage_reg(CFG_OCC_DELTA,  16'(RST_OCC_DELTA));
    stage_reg(CFG_ODDS_LIMIT, 16'd500);
    apply_regs();
    @(negedge clk);
    cmd_backlog.push_back(mk_read(36, 19));
    cmd_backlog.push_back(mk_read(37, 0));
    run_batch(130, 10);

    stage_reg(CFG_ODDS_LIMIT, 16'd0);
    apply_regs();
    run_batch(60, 30);

    stage_reg(CFG_FREE_DELTA, 16'd0);
    stage_reg(CFG_OCC_DELTA,  16'd0);
    stage_reg(CFG_ODDS_LIMIT, 16'h7FFF);
    stage_reg(CFG_MAP_WIDTH,  16'd1);
    stage_reg(CFG_MAP_HEIGHT, 16'd512);
    apply_regs();
    run_batch(60, 5);

    stage_reg(CFG_FREE_DELTA, -16'sd300);
    stage_reg(CFG_OCC_DELTA,  16'd900);
    stage_reg(CFG_MAP_WIDTH,  16'd512);
    stage_reg(CFG_MAP_HEIGHT, 16'd1);
    apply_regs();
    run_batch(60, 15);

    for (int p = 0; p < 5; p++) begin
      stage_reg(CFG_MAP_WIDTH,  {6'($urandom), 10'($urandom_range(1, 1023))});
      stage_reg(CFG_MAP_HEIGHT, {6'($urandom), 10'($urandom_range(1, 1023))});
      stage_reg(CFG_FREE_DELTA, ($urandom_range(0, 3) == 0) ? 16'h8000 :
                                -16'($urandom_range(0, 2000)));
      stage_reg(CFG_OCC_DELTA,  {1'($urandom), 15'($urandom_range(0, 3000))});
      stage_reg(CFG_ODDS_LIMIT, {1'($urandom), 15'($urandom_range(0, 32767))});
      apply_regs();
      run_batch(100, 5 * p);
    end

    // closing stretch at full rate
    stage_reg(CFG_MAP_WIDTH,  16'd512);
    stage_reg(CFG_MAP_HEIGHT, 16'd512);
    stage_reg(CFG_FREE_DELTA, RST_FREE_DELTA);
    stage_reg(CFG_OCC_DELTA,  16'(RST_OCC_DELTA));
    stage_reg(CFG_ODDS_LIMIT, 16'd2000);
    apply_regs();
    run_batch(100, 0);

    repeat (600) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
